FILE: rtl/core/smt_pkg.sv
// smt_pkg: constants and types shared by the subscription match table.
// No dependencies.
package smt_pkg;
  localparam int TABLE_DEPTH = 32;
  localparam int MAX_LISTED = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = 6;
  localparam int LST_W = $clog2(MAX_LISTED + 1);

  localparam logic [2:0] OP_SUB = 3'd0;
  localparam logic [2:0] OP_UNSUB = 3'd1;
  localparam logic [2:0] OP_UNSUB_ALL = 3'd2;
  localparam logic [2:0] OP_LIST = 3'd3;
  localparam logic [2:0] OP_IS_SUB = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_KEPT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  typedef struct packed {
    logic [15:0] conn;
    logic [31:0] key;
  } entry_t;

  // control from sequencer to every cell
  typedef struct packed {
    logic rotate;   // each cell takes its upper neighbor's word
    logic load;     // the selected cell takes the write word instead
  } cell_ctl_t;
endpackage

FILE: rtl/core/smt_cell.sv
// smt_cell: one table slot of the rotating chain.
// Depends on smt_pkg.
module smt_cell (
  input  logic               clk,
  input  smt_pkg::cell_ctl_t ctl,
  input  logic               sel,
  input  smt_pkg::entry_t    wr,
  input  smt_pkg::entry_t    prev,
  output smt_pkg::entry_t    word
);
  import smt_pkg::*;
  always_ff @(posedge clk) begin
    if (ctl.rotate) begin
      word <= (ctl.load && sel) ? wr : prev;
    end
  end
endmodule

FILE: rtl/core/subscription_match_table.sv
// subscription_match_table: top level, sequencer and chain of table cells.
// Depends on smt_pkg and smt_cell.
//
//  channel | ports                                        | handshake
//  in      | op, conn_id, type_key                        | start & !busy
//  out     | status, found, subscriber_id, entry_count,   | strobe, one cycle
//          | truncated, last                              |
//
// The table is a ring of TABLE_DEPTH cells; every op rotates it one full
// turn, examining cell 0 each cycle, then a finish state drives the final
// word and the sequencer returns to idle before the next word is accepted.
// List words leave during the scan, each one match behind. Reset clears
// only the count, the sequencer state, strobe and pend; cells above the
// count hold junk. Results cannot be stalled.
module subscription_match_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op,
  input  logic [15:0] conn_id,
  input  logic [31:0] type_key,
  output logic        strobe,
  output logic [1:0]  status,
  output logic        found,
  output logic [15:0] subscriber_id,
  output logic [5:0]  entry_count,
  output logic        truncated,
  output logic        last
);
  import smt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [2:0] cur_op;
  logic [15:0] cur_conn;
  logic [31:0] cur_key;
  logic [IDX_W:0] step;     // position of cell 0 word in the old table
  logic [IDX_W:0] count;    // entries before op
  logic [IDX_W:0] kept;     // entries written back so far
  logic hit;                // a match seen (first-match tracking)
  logic [LST_W-1:0] nlist;
  logic more;
  logic pend;               // a listed id waiting to be emitted
  logic [15:0] pend_id;

  entry_t cells [TABLE_DEPTH];
  entry_t head;
  entry_t wr;
  cell_ctl_t ctl;
  logic [IDX_W-1:0] wpos;

  logic live, m_pair, m_conn, m_key, drop_it, append, keep, emit;
  assign head = cells[0];
  assign live = (step < count);
  assign m_pair = live && head.conn == cur_conn && head.key == cur_key;
  assign m_conn = live && head.conn == cur_conn;
  assign m_key = live && head.key == cur_key;
  always_comb begin
    case (cur_op)
      OP_UNSUB: drop_it = m_pair && !hit;
      OP_UNSUB_ALL: drop_it = m_conn;
      default: drop_it = 1'b0;
    endcase
  end

  assign append = (cur_op == OP_SUB) && !hit && (count < (IDX_W+1)'(TABLE_DEPTH))
                  && (step == count);
  assign keep = (live && !drop_it) || append;
  always_comb begin
    wr = head;
    if (append) begin
      wr.conn = cur_conn;
      wr.key = cur_key;
    end
  end

  // Every cell shifts down each scan cycle. A kept word is written at
  // TABLE_DEPTH-1 minus the words not kept so far, so after the full turn
  // the kept words sit at cells 0..kept-1 in their old order.
  assign wpos = IDX_W'(TABLE_DEPTH - 1) - IDX_W'(step - kept);
  assign ctl.rotate = (state == S_SCAN);
  assign ctl.load = keep;

  assign emit = (state == S_SCAN) && (cur_op == OP_LIST) && m_key
                && (nlist != LST_W'(MAX_LISTED)) && pend;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      entry_t nb;
      logic wsel;
      if (g == TABLE_DEPTH - 1) begin : g_tail
        assign nb = head;
      end else begin : g_mid
        assign nb = cells[g+1];
      end
      assign wsel = (wpos == IDX_W'(g));
      smt_cell u_cell (.clk(clk), .ctl(ctl), .sel(wsel), .wr(wr), .prev(nb),
                       .word(cells[g]));
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      strobe <= 1'b0;
      pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          strobe <= 1'b0;
          if (start) begin
            state <= S_SCAN;
            cur_op <= op;
            cur_conn <= conn_id;
            cur_key <= type_key;
            step <= '0;
            hit <= 1'b0;
            kept <= '0;
            nlist <= '0;
            more <= 1'b0;
            pend <= 1'b0;
          end
        end
        S_SCAN: begin
          step <= step + 1'b1;
          strobe <= emit;
          if (m_pair) hit <= 1'b1;
          if (keep) kept <= kept + 1'b1;
          if (cur_op == OP_LIST && m_key) begin
            if (nlist == LST_W'(MAX_LISTED)) begin
              more <= 1'b1;
            end else begin
              if (pend) begin
                status <= ST_OK;
                found <= 1'b1;
                subscriber_id <= pend_id;
                entry_count <= CNT_W'(count);
                truncated <= 1'b0;
                last <= 1'b0;
              end
              pend <= 1'b1;
              pend_id <= head.conn;
              nlist <= nlist + 1'b1;
            end
          end
          if (step == (IDX_W+1)'(TABLE_DEPTH - 1)) begin
            state <= S_DONE;
          end
        end
        default: begin
          state <= S_IDLE;
          count <= kept;
          strobe <= 1'b1;
          found <= (cur_op == OP_LIST) ? pend : ((cur_op == OP_IS_SUB) ? hit : 1'b0);
          subscriber_id <= (cur_op == OP_LIST && pend) ? pend_id : '0;
          truncated <= (cur_op == OP_LIST) && pend && more;
          last <= 1'b1;
          entry_count <= CNT_W'(kept);
          case (cur_op)
            OP_SUB: status <= hit ? ST_KEPT :
                              ((count == (IDX_W+1)'(TABLE_DEPTH)) ? ST_FULL : ST_OK);
            OP_UNSUB, OP_UNSUB_ALL: status <= (kept != count) ? ST_OK : ST_NONE;
            OP_LIST: status <= pend ? ST_OK : ST_NONE;
            default: status <= ST_OK;
          endcase
        end
      endcase
    end
  end
  assign busy = (state != S_IDLE);
endmodule

FILE: tb/subscription_match_table_tb.sv
// Testbench for subscription_match_table: directed and random table operations,
// checked word by word against a behavioral table model in a scoreboard class.
// Depends on smt_pkg and the subscription_match_table RTL.
`timescale 1ns / 1ps

module subscription_match_table_tb;
  import smt_pkg::*;

  localparam logic [2:0] OP_COUNT = 3'd5;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [15:0] sid;
    logic [5:0]  cnt;
    logic        trunc;
    logic        last;
  } result_t;

  class table_scoreboard;
    logic [15:0] conns[$];
    logic [31:0] keys[$];
    result_t     pending[$];
    int          errors;
    int          checked;

    function void push(logic [1:0] st, logic f, logic [15:0] s, logic t, logic l);
      result_t r;
      r.status = st; r.found = f; r.sid = s;
      r.cnt = 6'(conns.size()); r.trunc = t; r.last = l;
      pending.push_back(r);
    endfunction

    function int find_pair(logic [15:0] c, logic [31:0] k);
      for (int i = 0; i < conns.size(); i++)
        if (conns[i] == c && keys[i] == k) return i;
      return -1;
    endfunction

    function void note_word(logic [2:0] op, logic [15:0] c, logic [31:0] k);
      int pos;
      int n;
      bit any;
      bit more;
      case (op)
        OP_SUB: begin
          if (find_pair(c, k) >= 0) push(ST_KEPT, 0, 0, 0, 1);
          else if (conns.size() >= TABLE_DEPTH) push(ST_FULL, 0, 0, 0, 1);
          else begin
            conns.push_back(c); keys.push_back(k);
            push(ST_OK, 0, 0, 0, 1);
          end
        end
        OP_UNSUB: begin
          pos = find_pair(c, k);
          if (pos >= 0) begin
            conns.delete(pos); keys.delete(pos);
            push(ST_OK, 0, 0, 0, 1);
          end else push(ST_NONE, 0, 0, 0, 1);
        end
        OP_UNSUB_ALL: begin
          any = 0;
          for (int i = conns.size() - 1; i >= 0; i--)
            if (conns[i] == c) begin
              conns.delete(i); keys.delete(i); any = 1;
            end
          push(any ? ST_OK : ST_NONE, 0, 0, 0, 1);
        end
        OP_LIST: begin
          n = 0; more = 0;
          for (int i = 0; i < conns.size(); i++) begin
            if (keys[i] != k) continue;
            if (n >= MAX_LISTED) begin
              more = 1; break;
            end
            push(ST_OK, 1, conns[i], 0, 0);
            n++;
          end
          if (n == 0) push(ST_NONE, 0, 0, 0, 1);
          else begin
            pending[$].trunc = more;
            pending[$].last = 1;
          end
        end
        OP_IS_SUB: push(ST_OK, find_pair(c, k) >= 0, 0, 0, 1);
        default: push(ST_OK, 0, 0, 0, 1);
      endcase
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: mismatch expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst, start, busy, strobe;
  logic [2:0]  op;
  logic [15:0] conn_id;
  logic [31:0] type_key;
  logic [1:0]  status;
  logic        found, truncated, last;
  logic [15:0] subscriber_id;
  logic [5:0]  entry_count;
  longint      cycles;
  bit          calm;
  int          sent;
  table_scoreboard sb;

  subscription_match_table uut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && strobe)
      sb.check_word('{status, found, subscriber_id, entry_count, truncated, last});
  end

  // one word; random idle cycles unless calm; start stays high until the
  // next word or the end of the run
  task automatic send(logic [2:0] o, logic [15:0] c, logic [31:0] k);
    while (!calm && $urandom_range(99) < 16) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1; op <= o; conn_id <= c; type_key <= k;
    do @(posedge clk); while (busy);
    sb.note_word(o, c, k);
    sent++;
  endtask

  // small pools so pairs collide
  function automatic logic [15:0] pick_conn();
    return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
  endfunction
  function automatic logic [31:0] pick_key();
    return ($urandom_range(9) == 0) ? $urandom : 32'(32'hA5A50000 + $urandom_range(3));
  endfunction

  initial begin
    sb = new;
    cycles = 0; calm = 0; sent = 0;
    rst = 1; start = 0; op = OP_SUB; conn_id = 0; type_key = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty cases, extremes, duplicates, fill past full, truncated list
    send(OP_LIST, 0, 32'hFFFF_FFFF);
    send(OP_UNSUB, 16'hFFFF, 0);
    send(OP_UNSUB_ALL, 0, 0);
    send(OP_SUB, 16'hFFFF, 32'hFFFF_FFFF);
    send(OP_SUB, 16'hFFFF, 32'hFFFF_FFFF);
    send(OP_IS_SUB, 16'hFFFF, 32'hFFFF_FFFF);
    send(OP_IS_SUB, 0, 32'hFFFF_FFFF);
    send(OP_SPARE_LO, 0, 0);
    send(OP_SPARE_HI, 16'hFFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 32; i++) send(OP_SUB, 16'(i), 32'h0);
    send(OP_SUB, 16'h1234, 32'h0);
    send(OP_LIST, 0, 32'h0);
    send(OP_LIST, 0, 32'hFFFF_FFFF);
    send(OP_COUNT, 0, 0);
    send(OP_UNSUB, 16'hFFFF, 32'hFFFF_FFFF);
    send(OP_UNSUB_ALL, 16'd3, 0);
    for (int i = 0; i < 32; i++) send(OP_UNSUB_ALL, 16'(i), 0);
    // random: subscribe-heavy mix; a calm stretch in the middle
    for (int n = 0; n < 200; n++) begin
      int r;
      calm = (n >= 80 && n < 130);
      r = $urandom_range(99);
      if (r < 40) send(OP_SUB, pick_conn(), pick_key());
      else if (r < 52) send(OP_UNSUB, pick_conn(), pick_key());
      else if (r < 58) send(OP_UNSUB_ALL, pick_conn(), $urandom);
      else if (r < 80) send(OP_LIST, 16'($urandom), pick_key());
      else if (r < 93) send(OP_IS_SUB, pick_conn(), pick_key());
      else send(3'($urandom_range(OP_COUNT, OP_SPARE_HI)), 16'($urandom), $urandom);
    end
    start <= 0;
    while (sb.pending.size() != 0 && cycles < 400000) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Ran %0d random and directed table operations, %0d result words checked.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > 500000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end
endmodule

FILE: subscription_match_table.f
rtl/core/smt_pkg.sv
rtl/core/smt_cell.sv
rtl/core/subscription_match_table.sv
tb/subscription_match_table_tb.sv
